### src/ilid_pkg.sv
package ilid_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // Wide enough for any slot index plus one over the whole capacity range.
    localparam int LIST_IDX_W = 9;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_READ   = 3'd3,
        CMD_WRITE  = 3'd4,
        CMD_COUNTS = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_WRITE  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic [LIST_IDX_W-1:0]   pos;
        logic [LIST_IDX_W-1:0]   used;
    } t_cell_ctl;

endpackage

### src/ilid_cell.sv
module ilid_cell #(
    parameter int IDX           = 0,
    parameter int ELEMENT_WIDTH = ilid_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ilid_pkg::t_cell_ctl               i_ctl,
    input  logic [ilid_pkg::LIST_IDX_W-1:0]   i_tap_a,
    input  logic [ilid_pkg::LIST_IDX_W-1:0]   i_tap_b,
    input  logic [ELEMENT_WIDTH-1:0]          i_word,
    input  logic [ELEMENT_WIDTH-1:0]          i_left,
    input  logic [ELEMENT_WIDTH-1:0]          i_right,
    output logic [ELEMENT_WIDTH-1:0]          o_slot,
    output logic [ELEMENT_WIDTH-1:0]          o_tap_a,
    output logic [ELEMENT_WIDTH-1:0]          o_tap_b
);
    import ilid_pkg::*;

    localparam logic [LIST_IDX_W-1:0] ME      = LIST_IDX_W'(IDX);
    localparam logic [LIST_IDX_W-1:0] ME_NEXT = LIST_IDX_W'(IDX + 1);

    logic [ELEMENT_WIDTH-1:0] r_slot;
    logic [ELEMENT_WIDTH-1:0] n_slot;

    always_comb begin
        n_slot = r_slot;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (ME == i_ctl.pos) begin
                    n_slot = i_word;
                end else if ((ME > i_ctl.pos) && (ME <= i_ctl.used)) begin
                    n_slot = i_left;
                end
            end
            CELL_REMOVE: begin
                if ((ME >= i_ctl.pos) && (ME_NEXT < i_ctl.used)) begin
                    n_slot = i_right;
                end else if (ME_NEXT == i_ctl.used) begin
                    n_slot = '0;
                end
            end
            CELL_WRITE: begin
                if (ME == i_ctl.pos) begin
                    n_slot = i_word;
                end
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot  = r_slot;
    assign o_tap_a = (ME == i_tap_a) ? r_slot : '0;
    assign o_tap_b = (ME == i_tap_b) ? r_slot : '0;

endmodule

### src/indexed_list_insert_delete.sv
// Ordered list of CAPACITY element words held in a row of slot cells, with
// zero meaning an empty slot. Each transaction carries one command and yields
// exactly one result transaction. All slots shift, write or hold in the same
// clock edge. The result appears in the cycle after acceptance in an output
// register; a new command is accepted in any cycle in which no result waits or
// the waiting result is taken in that same cycle, so a stalled result stalls
// the input. The non-empty count is kept incrementally from the single slot
// that each command overwrites or drops. Reset empties every slot.
module indexed_list_insert_delete #(
    parameter int CAPACITY      = ilid_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ilid_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // position [3:0], value [35:4], zero fill [39:36]
    input  logic [ilid_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // cmd [2:0]
    input  logic [ilid_pkg::CMD_W-1:0]          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // data_out [31:0], used_length [36:32], filled_count [41:37], zero fill [47:42]
    output logic [ilid_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // status [1:0]
    output logic [ilid_pkg::STATUS_W-1:0]       o_m_axis_tuser
);
    import ilid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [LIST_IDX_W-1:0] CAP_IDX = LIST_IDX_W'(CAPACITY);

    logic                      w_s_fire;
    logic                      w_m_fire;
    t_cmd                      w_cmd;
    logic [POS_W-1:0]          w_pos;
    logic [VALUE_W-1:0]        w_value;
    logic [ELEMENT_WIDTH-1:0]  w_word;
    logic [LIST_IDX_W-1:0]     w_pos_x;
    logic [LIST_IDX_W-1:0]     w_used_x;
    logic                      w_full;

    logic [CNT_W-1:0]          r_used;
    logic [CNT_W-1:0]          n_used;
    logic [CNT_W-1:0]          r_nonempty;
    logic [CNT_W-1:0]          n_nonempty;

    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [ELEMENT_WIDTH-1:0]  r_out_data;
    t_status                   r_out_status;
    logic [CNT_W-1:0]          r_out_used;
    logic [CNT_W-1:0]          r_out_nonempty;

    t_cell_ctl                 w_ctl;
    logic [LIST_IDX_W-1:0]     w_ctl_pos;
    logic [LIST_IDX_W-1:0]     w_tap_a_idx;
    logic [LIST_IDX_W-1:0]     w_tap_b_idx;
    t_cell_op                  w_op;
    t_status                   w_status;
    logic [ELEMENT_WIDTH-1:0]  w_data;
    logic                      w_grow;
    logic                      w_shrink;
    logic                      w_add;
    logic                      w_lose;

    logic [ELEMENT_WIDTH-1:0]  w_slot  [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  w_tap_a [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  w_tap_b [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  w_tap_a_val;
    logic [ELEMENT_WIDTH-1:0]  w_tap_b_val;
    logic [63:0]               w_data_ext;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_m_fire        = r_out_valid && i_m_axis_tready;

    assign w_cmd    = t_cmd'(i_s_axis_tuser);
    assign w_pos    = i_s_axis_tdata[POS_W-1:0];
    assign w_value  = i_s_axis_tdata[POS_W+VALUE_W-1:POS_W];
    assign w_word   = ELEMENT_WIDTH'(w_value);
    assign w_pos_x  = LIST_IDX_W'(w_pos);
    assign w_used_x = LIST_IDX_W'(r_used);
    assign w_full   = (r_used == CAP_CNT);

    assign w_tap_b_idx = w_pos_x + LIST_IDX_W'(1);

    always_comb begin
        unique case (w_cmd)
            CMD_APPEND, CMD_INSERT: begin
                w_tap_a_idx = w_used_x;
            end
            default: begin
                w_tap_a_idx = w_pos_x;
            end
        endcase
    end

    always_comb begin
        w_op      = CELL_HOLD;
        w_status  = ST_OK;
        w_data    = '0;
        w_grow    = 1'b0;
        w_shrink  = 1'b0;
        w_add     = 1'b0;
        w_lose    = 1'b0;
        w_ctl_pos = w_pos_x;
        unique case (w_cmd)
            CMD_APPEND: begin
                w_ctl_pos = w_used_x;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op   = CELL_INSERT;
                    w_grow = 1'b1;
                    w_add  = (w_word != '0);
                    w_lose = (w_tap_a_val != '0);
                end
            end
            CMD_INSERT: begin
                if (w_pos_x > w_used_x) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op   = CELL_INSERT;
                    w_grow = 1'b1;
                    w_add  = (w_word != '0);
                    w_lose = (w_tap_a_val != '0);
                end
            end
            CMD_REMOVE: begin
                if (w_pos_x >= w_used_x) begin
                    w_status = ST_RANGE;
                end else if (w_tap_a_val == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op     = CELL_REMOVE;
                    w_shrink = 1'b1;
                    w_lose   = 1'b1;
                    if (w_tap_b_idx < w_used_x) begin
                        w_data = w_tap_b_val;
                    end
                end
            end
            CMD_READ: begin
                if (w_pos_x >= CAP_IDX) begin
                    w_status = ST_RANGE;
                end else begin
                    w_data = w_tap_a_val;
                    if (w_tap_a_val == '0) begin
                        w_status = ST_EMPTY;
                    end
                end
            end
            CMD_WRITE: begin
                if (w_pos_x >= CAP_IDX) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op   = CELL_WRITE;
                    w_add  = (w_word != '0);
                    w_lose = (w_tap_a_val != '0);
                end
            end
            CMD_COUNTS: begin
                w_status = ST_OK;
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    assign w_ctl = '{op: (w_s_fire ? w_op : CELL_HOLD), pos: w_ctl_pos, used: w_used_x};

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ELEMENT_WIDTH-1:0] w_left;
            logic [ELEMENT_WIDTH-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_inner_l
                assign w_left = w_slot[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner_r
                assign w_right = w_slot[g+1];
            end
            ilid_cell #(
                .IDX           (g),
                .ELEMENT_WIDTH (ELEMENT_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_tap_a (w_tap_a_idx),
                .i_tap_b (w_tap_b_idx),
                .i_word  (w_word),
                .i_left  (w_left),
                .i_right (w_right),
                .o_slot  (w_slot[g]),
                .o_tap_a (w_tap_a[g]),
                .o_tap_b (w_tap_b[g])
            );
        end
    endgenerate

    always_comb begin
        w_tap_a_val = '0;
        w_tap_b_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_tap_a_val = w_tap_a_val | w_tap_a[i];
            w_tap_b_val = w_tap_b_val | w_tap_b[i];
        end
    end

    always_comb begin
        n_used = r_used;
        if (w_s_fire && w_grow) begin
            n_used = r_used + CNT_W'(1);
        end else if (w_s_fire && w_shrink) begin
            n_used = r_used - CNT_W'(1);
        end
        n_nonempty = r_nonempty;
        if (w_s_fire) begin
            n_nonempty = r_nonempty + CNT_W'(w_add) - CNT_W'(w_lose);
        end
        n_out_valid = r_out_valid;
        if (w_s_fire) begin
            n_out_valid = 1'b1;
        end else if (w_m_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_nonempty  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_used      <= n_used;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_out_data     <= w_data;
            r_out_status   <= w_status;
            r_out_used     <= n_used;
            r_out_nonempty <= n_nonempty;
        end
    end

    assign w_data_ext      = 64'(r_out_data);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {
        (OUT_TDATA_W - VALUE_W - 2 * LEN_W)'(0),
        LEN_W'(r_out_nonempty),
        LEN_W'(r_out_used),
        w_data_ext[VALUE_W-1:0]
    };

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CAP_CNT)
        else $error("Used length exceeds capacity.");

    a_nonempty_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nonempty <= CAP_CNT)
        else $error("Non-empty count exceeds capacity.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_FULL) |-> (r_used == CAP_CNT))
        else $error("Full status reported while the list is not full.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> r_out_valid && (r_out_used == r_used))
        else $error("Accepted transaction did not produce a matching result.");
`endif

endmodule

### tb/sv/ilid_tb_pkg.sv
`timescale 1ns / 1ps

package ilid_tb_pkg;

    import ilid_pkg::*;

    // Command codes outside the defined set; the block must refuse them.
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [VALUE_W-1:0] data;
        t_status            status;
        logic [LEN_W-1:0]   used;
        logic [LEN_W-1:0]   filled;
    } t_list_result;

    class list_scoreboard;
        logic [ELEMENT_WIDTH_DEF-1:0] slot_words [CAPACITY_DEF];
        int unsigned                  used_len;
        t_list_result                 expected_results [$];
        int unsigned                  failures;

        function new();
            foreach (slot_words[i]) slot_words[i] = '0;
            used_len = 0;
            failures = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [VALUE_W-1:0] word);
            t_list_result res;
            int unsigned  n_filled;
            res.data   = '0;
            res.status = ST_OK;
            case (cmd)
                CMD_APPEND: begin
                    if (used_len >= CAPACITY_DEF) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_words[used_len] = word;
                        used_len++;
                    end
                end
                CMD_INSERT: begin
                    if (pos > used_len) begin
                        res.status = ST_RANGE;
                    end else if (used_len >= CAPACITY_DEF) begin
                        res.status = ST_FULL;
                    end else begin
                        for (int i = used_len; i > pos; i--)
                            slot_words[i] = slot_words[i-1];
                        slot_words[pos] = word;
                        used_len++;
                    end
                end
                CMD_REMOVE: begin
                    if (pos >= used_len) begin
                        res.status = ST_RANGE;
                    end else if (slot_words[pos] == '0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        for (int i = pos; i + 1 < used_len; i++)
                            slot_words[i] = slot_words[i+1];
                        slot_words[used_len-1] = '0;
                        used_len--;
                        res.data = slot_words[pos];
                    end
                end
                CMD_READ: begin
                    if (pos >= CAPACITY_DEF) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.data = slot_words[pos];
                        if (res.data == '0) res.status = ST_EMPTY;
                    end
                end
                CMD_WRITE: begin
                    if (pos >= CAPACITY_DEF) res.status = ST_RANGE;
                    else slot_words[pos] = word;
                end
                CMD_COUNTS: begin
                end
                default: begin
                    res.status = ST_RANGE;
                end
            endcase
            n_filled = 0;
            foreach (slot_words[i]) if (slot_words[i] != '0) n_filled++;
            res.used   = used_len[LEN_W-1:0];
            res.filled = n_filled[LEN_W-1:0];
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [VALUE_W-1:0] data, t_status status,
                                   logic [LEN_W-1:0] used, logic [LEN_W-1:0] filled);
            t_list_result exp_res;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: data %h status %0d used %0d filled %0d",
                             data, status, used, filled);
                return;
            end
            exp_res = expected_results.pop_front();
            if (exp_res.data !== data || exp_res.status !== status ||
                exp_res.used !== used || exp_res.filled !== filled) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"mismatch: expected data %h status %0d used %0d filled %0d,",
                              " got data %h status %0d used %0d filled %0d"},
                             exp_res.data, exp_res.status, exp_res.used, exp_res.filled,
                             data, status, used, filled);
            end
        endfunction
    endclass

endpackage

### tb/sv/indexed_list_insert_delete_tb.sv
`timescale 1ns / 1ps

module indexed_list_insert_delete_tb;

    import ilid_pkg::*;
    import ilid_tb_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic [CMD_W-1:0]        i_s_axis_tuser = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic [STATUS_W-1:0]     o_m_axis_tuser;

    int unsigned    src_idle_pct = 0;
    int unsigned    sink_stall_pct = 0;
    list_scoreboard sb = new();

    indexed_list_insert_delete dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_command(i_s_axis_tuser, i_s_axis_tdata[3:0], i_s_axis_tdata[35:4]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata[31:0], t_status'(o_m_axis_tuser),
                                o_m_axis_tdata[36:32], o_m_axis_tdata[41:37]);
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] word);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, word, pos};
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_command();
        int unsigned      r;
        int unsigned      len;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VALUE_W-1:0] word;
        len = sb.used_len;
        r = $urandom_range(0, 99);
        if (r < 18)      cmd = CMD_APPEND;
        else if (r < 36) cmd = CMD_INSERT;
        else if (r < 66) cmd = CMD_REMOVE;
        else if (r < 78) cmd = CMD_READ;
        else if (r < 88) cmd = CMD_WRITE;
        else if (r < 96) cmd = CMD_COUNTS;
        else             cmd = $urandom_range(0, 1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
        if ($urandom_range(0, 99) < 25)
            pos = POS_W'($urandom_range(0, 15));
        else if (cmd == CMD_INSERT)
            pos = (len > 15) ? 4'd15 : POS_W'($urandom_range(0, len));
        else if (len > 0)
            pos = POS_W'($urandom_range(0, len - 1));
        else
            pos = POS_W'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 8)       word = '0;
        else if (r < 14) word = '1;
        else             word = $urandom;
        send_command(cmd, pos, word);
    endtask

    task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct,
                             input int unsigned n_items);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n_items) random_command();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_command(CMD_COUNTS, 4'd0, '0);
        send_command(CMD_READ, 4'd0, '0);
        send_command(CMD_REMOVE, 4'd0, '0);
        send_command(CMD_INSERT, 4'd15, 32'h1234_5678);
        send_command(CMD_APPEND, 4'd0, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 4'd0, 32'h0000_0001);
        send_command(CMD_APPEND, 4'd0, 32'h0000_0000);
        send_command(CMD_REMOVE, 4'd2, '0);
        send_command(CMD_WRITE, 4'd12, 32'h5A5A_5A5A);
        send_command(CMD_READ, 4'd12, '0);
        while (sb.used_len < CAPACITY_DEF) send_command(CMD_APPEND, 4'd0, $urandom | 32'd1);
        send_command(CMD_APPEND, 4'd0, 32'hA5A5_A5A5);
        send_command(CMD_INSERT, 4'd5, 32'hA5A5_A5A5);
        send_command(CMD_READ, 4'd15, '0);
        send_command(CMD_REMOVE, 4'd15, '0);
        send_command(CMD_UNDEF_LO, 4'd3, 32'hFFFF_FFFF);
        send_command(CMD_UNDEF_HI, 4'd3, 32'hFFFF_FFFF);

        run_phase(0, 0, 220);
        run_phase(84, 0, 150);
        hold_until_drained();
        run_phase(0, 84, 150);
        run_phase(24, 24, 200);
        run_phase(0, 0, 130);

        sink_stall_pct = 0;
        hold_until_drained();
        repeat (8) @(negedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
src/ilid_pkg.sv
src/ilid_cell.sv
src/indexed_list_insert_delete.sv
tb/sv/ilid_tb_pkg.sv
tb/sv/indexed_list_insert_delete_tb.sv
